/* sv/bsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types, widths and codes for the bpsk sync word phase resolver.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int MAX_SYNC_BITS_DEF = 64;

    localparam int SAMPLE_W   = 8;
    localparam int CORR_OUT_W = 8;
    localparam int LEN_W      = 7;
    localparam int CMP_W      = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int TAP_W      = 2;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_PATTERN  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_LENGTH   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEARCH_LOCKED = 2'd3;

    // ternary window tap codes
    localparam logic [TAP_W-1:0] TAP_ERASE = 2'b00;
    localparam logic [TAP_W-1:0] TAP_PLUS  = 2'b01;
    localparam logic [TAP_W-1:0] TAP_MINUS = 2'b11;

    typedef enum logic [1:0] {
        PH_UNKNOWN = 2'd0,
        PH_ZERO    = 2'd1,
        PH_180     = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        DET_NONE = 2'd0,
        DET_ZERO = 2'd1,
        DET_180  = 2'd2
    } t_detect;

endpackage

/* sv/bsr_corr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_corr
// Correlates the ternary sample window with the sync word through a
// balanced adder tree. Tap 0 is the newest sample and meets pattern bit 0.
// ----------------------------------------------------------------------------
module bsr_corr #(
    parameter int MAX_BITS = bsr_pkg::MAX_SYNC_BITS_DEF,
    parameter int NW       = $clog2(MAX_BITS + 1),
    parameter int CORR_W   = $clog2(MAX_BITS + 1) + 1
) (
    input  logic [MAX_BITS-1:0][bsr_pkg::TAP_W-1:0] i_taps,
    input  logic [MAX_BITS-1:0]                     i_pattern,
    input  logic [NW-1:0]                           i_len,
    output logic signed [CORR_W-1:0]                o_corr
);

    localparam int LEVELS = $clog2(MAX_BITS);
    localparam int LEAVES = 2 ** LEVELS;
    localparam int NODES  = 2 * LEAVES - 1;

    logic signed [CORR_W-1:0] w_node [NODES];

    genvar g;
    generate
        for (g = 0; g < LEAVES; g++) begin : g_leaf
            if (g < MAX_BITS) begin : g_used
                logic signed [bsr_pkg::TAP_W-1:0] w_tap;
                logic signed [CORR_W-1:0]         w_ext;
                assign w_tap = i_taps[g];
                assign w_ext = CORR_W'(w_tap);
                // bits past the length in use do not count
                assign w_node[LEAVES-1+g] = (i_len > NW'(g)) ?
                    (i_pattern[g] ? w_ext : -w_ext) : '0;
            end else begin : g_pad
                assign w_node[LEAVES-1+g] = '0;
            end
        end
        for (g = 0; g < LEAVES - 1; g++) begin : g_add
            assign w_node[g] = w_node[2*g+1] + w_node[2*g+2];
        end
    endgenerate

    assign o_corr = w_node[0];

endmodule

/* sv/bpsk_sync_word_phase_resolver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsk_sync_word_phase_resolver
// Hard-bit sync word correlator that resolves the bpsk phase ambiguity.
//
// Input channel: i_valid / o_stall carry one hard-bit sample per transfer.
// Output channel: o_valid / i_stall carry one result per input sample: the
// phase-corrected sample, the phase status, a detection code and the
// window correlation.
// Configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_addr
// (0 sync pattern, 1 sync length, 2 tolerance, 3 search lock); write only
// while no sample is in flight.
// o_valid rises once the sample has passed the input register and the
// result register. One sample per cycle is sustained while the receiver
// does not stall: an input register feeds the window shift, the adder tree
// and the phase decision, whose outputs land in the result register.
// Reset clears the window to erasures, the phase to unknown, the fill
// count to zero and the registers to pattern 0, length 64, tolerance 0,
// unlocked. When the receiver stalls, the result register holds; o_stall
// follows i_stall in the same cycle once both registers hold a sample, and
// an empty input register still takes one more sample first.
// ----------------------------------------------------------------------------
module bpsk_sync_word_phase_resolver #(
    parameter int MAX_SYNC_BITS = bsr_pkg::MAX_SYNC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [bsr_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [bsr_pkg::SAMPLE_W-1:0]    o_out_sample,
    output logic [1:0]                             o_phase_status,
    output logic [1:0]                             o_detected,
    output logic signed [bsr_pkg::CORR_OUT_W-1:0]  o_correlation,
    input  logic                                   i_cfg_wr_en,
    input  logic [bsr_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [bsr_pkg::CFG_DATA_W-1:0]         i_cfg_wdata
);

    localparam int NW     = $clog2(MAX_SYNC_BITS + 1);
    localparam int CORR_W = $clog2(MAX_SYNC_BITS + 1) + 1;
    localparam int CMP_W  = bsr_pkg::CMP_W;
    localparam int LEN_W  = bsr_pkg::LEN_W;
    localparam int SW     = bsr_pkg::SAMPLE_W;

    // configuration registers
    logic [bsr_pkg::CFG_DATA_W-1:0] r_sync_pattern;
    logic [LEN_W-1:0]               r_sync_length;
    logic [LEN_W-1:0]               r_tolerance;
    logic                           r_search_locked;

    // input stage
    logic                 r_a_valid;
    logic signed [SW-1:0] r_a_sample;

    // block state
    logic [MAX_SYNC_BITS-1:0][bsr_pkg::TAP_W-1:0] r_window;
    logic [NW-1:0]                                r_fill;
    bsr_pkg::t_phase                              r_phase;

    // result stage
    logic                           r_b_valid;
    logic signed [SW-1:0]           r_out_sample;
    bsr_pkg::t_phase                r_phase_st;
    bsr_pkg::t_detect               r_det;
    logic signed [CORR_W-1:0]       r_corr;

    logic                                         w_move;
    logic [bsr_pkg::TAP_W-1:0]                    w_tap;
    logic [MAX_SYNC_BITS-1:0][bsr_pkg::TAP_W-1:0] n_window;
    logic [NW-1:0]                                n_fill;
    logic [NW-1:0]                                w_len;
    logic signed [CORR_W-1:0]                     w_corr;
    logic signed [CMP_W-1:0]                      w_corr_x;
    logic signed [CMP_W-1:0]                      w_len_x;
    logic signed [CMP_W-1:0]                      w_lo;
    logic                                         w_hit0;
    logic                                         w_hit180;
    bsr_pkg::t_phase                              n_phase;
    bsr_pkg::t_detect                             n_det;
    logic signed [SW-1:0]                         n_out_sample;

    // input stage hands over when the result register is free or draining
    assign w_move  = r_a_valid && (!r_b_valid || !i_stall);
    assign o_stall = r_a_valid && !w_move;

    always_comb begin
        if (r_a_sample == SW'(0)) begin
            w_tap = bsr_pkg::TAP_MINUS;
        end else if (r_a_sample == SW'(1)) begin
            w_tap = bsr_pkg::TAP_PLUS;
        end else begin
            w_tap = bsr_pkg::TAP_ERASE;
        end
    end

    assign n_window = {r_window[MAX_SYNC_BITS-2:0], w_tap};
    assign n_fill   = (r_fill == NW'(MAX_SYNC_BITS)) ? r_fill : r_fill + NW'(1);

    // length zero acts as one, long lengths clamp to the window size
    always_comb begin
        if (r_sync_length == '0) begin
            w_len = NW'(1);
        end else if (r_sync_length > LEN_W'(MAX_SYNC_BITS)) begin
            w_len = NW'(MAX_SYNC_BITS);
        end else begin
            w_len = NW'(r_sync_length);
        end
    end

    bsr_corr #(
        .MAX_BITS (MAX_SYNC_BITS),
        .NW       (NW),
        .CORR_W   (CORR_W)
    ) u_corr (
        .i_taps    (n_window),
        .i_pattern (r_sync_pattern[MAX_SYNC_BITS-1:0]),
        .i_len     (w_len),
        .o_corr    (w_corr)
    );

    assign w_corr_x = CMP_W'(w_corr);
    assign w_len_x  = signed'(CMP_W'(w_len));
    assign w_lo     = w_len_x - signed'(CMP_W'(r_tolerance));
    assign w_hit0   = (w_corr_x >= w_lo) && (w_corr_x <= w_len_x);
    assign w_hit180 = (-w_corr_x >= w_lo) && (-w_corr_x <= w_len_x);

    always_comb begin
        n_phase = r_phase;
        n_det   = bsr_pkg::DET_NONE;
        if (!r_search_locked && (n_fill >= w_len)) begin
            if (w_hit0) begin
                n_phase = bsr_pkg::PH_ZERO;
                n_det   = bsr_pkg::DET_ZERO;
            end else if (w_hit180) begin
                n_phase = bsr_pkg::PH_180;
                n_det   = bsr_pkg::DET_180;
            end
        end
    end

    always_comb begin
        case (n_phase)
            bsr_pkg::PH_ZERO: n_out_sample = {{(SW-1){1'b0}}, ~r_a_sample[0]};
            bsr_pkg::PH_180:  n_out_sample = r_a_sample;
            default:          n_out_sample = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pattern  <= '0;
            r_sync_length   <= LEN_W'(64);
            r_tolerance     <= '0;
            r_search_locked <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                bsr_pkg::CFG_SYNC_PATTERN:  r_sync_pattern  <= i_cfg_wdata;
                bsr_pkg::CFG_SYNC_LENGTH:   r_sync_length   <= i_cfg_wdata[LEN_W-1:0];
                bsr_pkg::CFG_TOLERANCE:     r_tolerance     <= i_cfg_wdata[LEN_W-1:0];
                bsr_pkg::CFG_SEARCH_LOCKED: r_search_locked <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!o_stall) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_a_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_fill   <= '0;
            r_phase  <= bsr_pkg::PH_UNKNOWN;
        end else if (w_move) begin
            r_window <= n_window;
            r_fill   <= n_fill;
            r_phase  <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_move) begin
            r_b_valid <= 1'b1;
        end else if (!i_stall) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_sample <= n_out_sample;
            r_phase_st   <= n_phase;
            r_det        <= n_det;
            r_corr       <= w_corr;
        end
    end

    assign o_valid        = r_b_valid;
    assign o_out_sample   = r_out_sample;
    assign o_phase_status = r_phase_st;
    assign o_detected     = r_det;
    assign o_correlation  = bsr_pkg::CORR_OUT_W'(r_corr);

    // a detection always agrees with the phase it reports
    a_det_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_det == bsr_pkg::DET_ZERO) |-> (r_phase_st == bsr_pkg::PH_ZERO))
        else $error("detect at 0 degrees without phase 0");

    a_det_180: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_det == bsr_pkg::DET_180) |-> (r_phase_st == bsr_pkg::PH_180))
        else $error("detect at 180 degrees without phase 180");

    // locked search reports no detection
    a_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_search_locked) |=> (r_det == bsr_pkg::DET_NONE))
        else $error("detection while search locked");

    // once resolved, the phase never falls back to unknown
    a_phase_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != bsr_pkg::PH_UNKNOWN) |=> (r_phase != bsr_pkg::PH_UNKNOWN))
        else $error("phase returned to unknown");

    a_fill_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= NW'(MAX_SYNC_BITS))
        else $error("fill count past window size");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bpsk sync word phase resolver.
//
// A directed opening covers sample extremes, short, zero and oversized sync
// lengths, wide tolerance and the locked search. It is followed by phases
// of framed traffic under changing register settings. A frame is the sync
// word, sent straight or inverted and sometimes damaged, then random payload
// bits, with noise frames mixed in. A scoreboard keeps its own copy of the
// window, phase and registers, predicts every result and compares field by
// field. The sender pauses in random gaps and the receiver stalls in modes.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic signed [bsr_pkg::SAMPLE_W-1:0]   out_sample;
        bsr_pkg::t_phase                       phase;
        bsr_pkg::t_detect                      det;
        logic signed [bsr_pkg::CORR_OUT_W-1:0] corr;
    } t_resolved;

    class t_resolver_scoreboard;
        logic [bsr_pkg::CFG_DATA_W-1:0] sync_bits;
        logic [bsr_pkg::LEN_W-1:0]      sync_len;
        logic [bsr_pkg::LEN_W-1:0]      tol;
        logic                           locked;
        logic [bsr_pkg::TAP_W-1:0]      taps [bsr_pkg::MAX_SYNC_BITS_DEF];
        bsr_pkg::t_phase                phase;
        int                             fill;
        t_resolved                      pending [$];
        int                             errors;
        int                             results;
        int                             hits_zero;
        int                             hits_180;
        int                             locked_items;

        function new();
            sync_bits = '0;
            sync_len  = 7'd64;
            tol       = '0;
            locked    = 1'b0;
            foreach (taps[k]) taps[k] = bsr_pkg::TAP_ERASE;
            phase     = bsr_pkg::PH_UNKNOWN;
            fill      = 0;
            errors    = 0;
            results   = 0;
            hits_zero = 0;
            hits_180  = 0;
            locked_items = 0;
        endfunction

        function void write_reg(logic [bsr_pkg::CFG_ADDR_W-1:0] idx,
                                logic [bsr_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                bsr_pkg::CFG_SYNC_PATTERN:  sync_bits = d;
                bsr_pkg::CFG_SYNC_LENGTH:   sync_len  = d[bsr_pkg::LEN_W-1:0];
                bsr_pkg::CFG_TOLERANCE:     tol       = d[bsr_pkg::LEN_W-1:0];
                bsr_pkg::CFG_SEARCH_LOCKED: locked    = d[0];
                default: ;
            endcase
        endfunction

        // sync length actually in use
        function int span();
            if (sync_len == 0) return 1;
            if (sync_len > bsr_pkg::MAX_SYNC_BITS_DEF) return bsr_pkg::MAX_SYNC_BITS_DEF;
            return int'(sync_len);
        endfunction

        // shift one accepted sample in and queue the result it must produce
        function void note_sample(logic signed [bsr_pkg::SAMPLE_W-1:0] s);
            t_resolved r;
            int        n;
            int        c;
            int        w;
            int        t;
            n = span();
            t = int'(tol);
            c = 0;
            for (int k = bsr_pkg::MAX_SYNC_BITS_DEF - 1; k > 0; k--) taps[k] = taps[k-1];
            if (s == 8'sd0)      taps[0] = bsr_pkg::TAP_MINUS;
            else if (s == 8'sd1) taps[0] = bsr_pkg::TAP_PLUS;
            else                 taps[0] = bsr_pkg::TAP_ERASE;
            if (fill < bsr_pkg::MAX_SYNC_BITS_DEF) fill++;
            for (int k = 0; k < n; k++) begin
                case (taps[k])
                    bsr_pkg::TAP_PLUS:  w = 1;
                    bsr_pkg::TAP_MINUS: w = -1;
                    default:            w = 0;
                endcase
                if (sync_bits[k]) c += w;
                else c -= w;
            end
            r.det = bsr_pkg::DET_NONE;
            if (locked) locked_items++;
            if (!locked && fill >= n) begin
                if (c >= n - t && c <= n) begin
                    phase = bsr_pkg::PH_ZERO;
                    r.det = bsr_pkg::DET_ZERO;
                    hits_zero++;
                end else if (-c >= n - t && -c <= n) begin
                    phase = bsr_pkg::PH_180;
                    r.det = bsr_pkg::DET_180;
                    hits_180++;
                end
            end
            case (phase)
                bsr_pkg::PH_ZERO: r.out_sample = {7'b0, ~s[0]};
                bsr_pkg::PH_180:  r.out_sample = s;
                default:          r.out_sample = '0;
            endcase
            r.phase = phase;
            r.corr  = c[bsr_pkg::CORR_OUT_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic signed [bsr_pkg::SAMPLE_W-1:0] o_s, logic [1:0] ph,
                                   logic [1:0] det,
                                   logic signed [bsr_pkg::CORR_OUT_W-1:0] c);
            t_resolved r;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected (out %0d, phase %0d, det %0d)",
                         $time, o_s, ph, det);
                errors++;
                return;
            end
            r = pending.pop_front();
            results++;
            if (o_s !== r.out_sample) begin
                $display("%0t: out_sample expected %0d, actual %0d", $time, r.out_sample, o_s);
                errors++;
            end
            if (ph !== r.phase) begin
                $display("%0t: phase_status expected %0d, actual %0d", $time, r.phase, ph);
                errors++;
            end
            if (det !== r.det) begin
                $display("%0t: detected expected %0d, actual %0d", $time, r.det, det);
                errors++;
            end
            if (c !== r.corr) begin
                $display("%0t: correlation expected %0d, actual %0d", $time, r.corr, c);
                errors++;
            end
        endfunction
    endclass

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_valid = 1'b0;
    logic                                  o_stall;
    logic signed [bsr_pkg::SAMPLE_W-1:0]   i_sample = '0;
    logic                                  o_valid;
    logic                                  i_stall = 1'b0;
    logic signed [bsr_pkg::SAMPLE_W-1:0]   o_out_sample;
    logic [1:0]                            o_phase_status;
    logic [1:0]                            o_detected;
    logic signed [bsr_pkg::CORR_OUT_W-1:0] o_correlation;
    logic                                  i_cfg_wr_en = 1'b0;
    logic [bsr_pkg::CFG_ADDR_W-1:0]        i_cfg_addr = '0;
    logic [bsr_pkg::CFG_DATA_W-1:0]        i_cfg_wdata = '0;

    t_resolver_scoreboard sb = new();

    int burst_left = 0;
    bit gaps_on = 1'b1;
    int stall_mode = 0;
    int stall_run = 0;
    int samples_sent = 0;
    int settings_used = 0;

    bpsk_sync_word_phase_resolver u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_sample   (o_out_sample),
        .o_phase_status (o_phase_status),
        .o_detected     (o_detected),
        .o_correlation  (o_correlation),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: quiet, light random or heavy stall stretches
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_run  = $urandom_range(40, 300);
        end else begin
            stall_run--;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 2) == 0);
                default: i_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_sample(i_sample);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_out_sample, o_phase_status, o_detected, o_correlation);
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_sample(input logic signed [bsr_pkg::SAMPLE_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on) begin
                gap = $urandom_range(1, 5);
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_sample <= v;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        samples_sent++;
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [bsr_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [bsr_pkg::CFG_DATA_W-1:0] d);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= d;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.write_reg(idx, d);
        @(negedge i_clk);
    endtask

    task automatic pick_settings(input int ph);
        logic [bsr_pkg::CFG_DATA_W-1:0] pat;
        logic [bsr_pkg::LEN_W-1:0]      len;
        logic [bsr_pkg::LEN_W-1:0]      tl;
        logic                           lk;
        logic [3:0]                     wmask;
        pat   = {$urandom, $urandom};
        len   = ($urandom_range(0, 3) == 0) ? bsr_pkg::LEN_W'($urandom_range(13, 64))
                                            : bsr_pkg::LEN_W'($urandom_range(2, 12));
        tl    = ($urandom_range(0, 9) == 0) ? bsr_pkg::LEN_W'($urandom_range(0, 127))
                                            : bsr_pkg::LEN_W'($urandom_range(0, int'(len) / 3));
        lk    = ($urandom_range(0, 5) == 0);
        wmask = 4'($urandom_range(1, 15));
        case (ph)
            0: begin len = 7'd64; tl = '0; lk = 1'b0; wmask = 4'hF; end
            1: begin len = 7'd1; tl = '0; lk = 1'b0; wmask = 4'hF; end
            2: begin len = '0; lk = 1'b0; wmask[bsr_pkg::CFG_SYNC_LENGTH] = 1'b1; end
            3: begin
                len = 7'd127; tl = bsr_pkg::LEN_W'($urandom_range(0, 8)); lk = 1'b0;
                wmask = 4'hF;
            end
            4: begin tl = 7'd127; wmask[bsr_pkg::CFG_TOLERANCE] = 1'b1; end
            5: begin pat = '0; wmask[bsr_pkg::CFG_SYNC_PATTERN] = 1'b1; end
            6: begin pat = '1; wmask[bsr_pkg::CFG_SYNC_PATTERN] = 1'b1; end
            7: begin lk = 1'b1; wmask[bsr_pkg::CFG_SEARCH_LOCKED] = 1'b1; end
            8: begin len = 7'd64; tl = 7'd64; lk = 1'b0; wmask = 4'hF; end
            default: ;
        endcase
        if (wmask[bsr_pkg::CFG_SYNC_PATTERN])  write_reg(bsr_pkg::CFG_SYNC_PATTERN, pat);
        if (wmask[bsr_pkg::CFG_SYNC_LENGTH])   write_reg(bsr_pkg::CFG_SYNC_LENGTH, 64'(len));
        if (wmask[bsr_pkg::CFG_TOLERANCE])     write_reg(bsr_pkg::CFG_TOLERANCE, 64'(tl));
        if (wmask[bsr_pkg::CFG_SEARCH_LOCKED]) write_reg(bsr_pkg::CFG_SEARCH_LOCKED, 64'(lk));
        settings_used++;
    endtask

    // sync word (straight or inverted, sometimes damaged) then payload, or plain noise
    task automatic send_frame(output int cnt);
        int                                  n;
        int                                  style;
        int                                  tail;
        logic                                inv;
        logic signed [bsr_pkg::SAMPLE_W-1:0] v;
        n     = sb.span();
        style = $urandom_range(0, 9);
        cnt   = 0;
        if (style < 7) begin
            inv = 1'($urandom_range(0, 1));
            for (int k = n - 1; k >= 0; k--) begin
                v = {7'b0, sb.sync_bits[k] ^ inv};
                if (style == 6 && $urandom_range(0, 7) == 0)
                    v = signed'(bsr_pkg::SAMPLE_W'($urandom_range(0, 255)));
                push_sample(v);
                cnt++;
            end
            tail = $urandom_range(0, 24);
        end else begin
            tail = $urandom_range(4, 40);
        end
        repeat (tail) begin
            if ($urandom_range(0, 19) == 0)
                v = signed'(bsr_pkg::SAMPLE_W'($urandom_range(0, 255)));
            else
                v = signed'(bsr_pkg::SAMPLE_W'($urandom_range(0, 1)));
            push_sample(v);
            cnt++;
        end
    endtask

    initial begin : stimulus
        logic signed [bsr_pkg::SAMPLE_W-1:0] opening [6];
        int got;
        int in_phase;
        opening = '{8'sd0, 8'sd1, -8'sd128, 8'sd127, -8'sd1, 8'sd2};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, window still filling so nothing may match
        foreach (opening[k]) push_sample(opening[k]);
        wait_results_drained();
        // zero length runs as one bit: each hard bit sets the phase
        write_reg(bsr_pkg::CFG_SYNC_PATTERN, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(bsr_pkg::CFG_SYNC_LENGTH, 64'd0);
        push_sample(8'sd0);
        push_sample(8'sd1);
        push_sample(8'sd5);
        push_sample(-8'sd128);
        wait_results_drained();
        // tolerance above length: phase 0 range reaches negative values
        write_reg(bsr_pkg::CFG_SYNC_LENGTH, 64'd3);
        write_reg(bsr_pkg::CFG_TOLERANCE, 64'd5);
        push_sample(8'sd0);
        push_sample(8'sd0);
        push_sample(8'sd1);
        wait_results_drained();
        write_reg(bsr_pkg::CFG_SEARCH_LOCKED, 64'd1);
        push_sample(8'sd1);
        push_sample(8'sd0);
        push_sample(8'sd1);
        wait_results_drained();
        write_reg(bsr_pkg::CFG_SEARCH_LOCKED, 64'd0);
        // oversized length is clipped to the full window
        write_reg(bsr_pkg::CFG_SYNC_LENGTH, 64'd100);
        write_reg(bsr_pkg::CFG_TOLERANCE, 64'd64);
        push_sample(8'sd1);
        push_sample(-8'sd2);
        wait_results_drained();

        for (int ph = 0; ph < 14; ph++) begin
            pick_settings(ph);
            gaps_on  = ($urandom_range(0, 3) != 0);
            in_phase = 0;
            while (in_phase < 84) begin
                send_frame(got);
                in_phase += got;
                // occasional hold-off until the pipeline is empty
                if ($urandom_range(0, 15) == 0) wait_results_drained();
            end
            wait_results_drained();
        end

        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
            sb.errors += sb.pending.size();
        end
        $display("%0d samples, %0d results over %0d register settings", samples_sent,
                 sb.results, settings_used + 5);
        $display("sync hits: %0d at 0 deg, %0d at 180 deg; %0d samples while locked",
                 sb.hits_zero, sb.hits_180, sb.locked_items);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout at %0t with %0d results outstanding", $time, sb.pending.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/bsr_pkg.sv
sv/bsr_corr.sv
sv/bpsk_sync_word_phase_resolver.sv
sim/tb.sv
